FILE: rtl/smckrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smckrp_pkg
// Codes, key names and fixed values of the key-read port controller.
// ----------------------------------------------------------------------------
package smckrp_pkg;

  // Port codes
  localparam logic [1:0] PortData   = 2'd0;
  localparam logic [1:0] PortCmd    = 2'd1;
  localparam logic [1:0] PortErr    = 2'd2;

  // Command codes
  localparam logic [7:0] CmdRead    = 8'h10;

  // Status bits
  localparam logic [7:0] StIdle     = 8'h00;
  localparam logic [7:0] StReady    = 8'h01;
  localparam logic [7:0] StAck      = 8'h04;
  localparam logic [7:0] StNewCmd   = 8'h08;

  // Error codes
  localparam logic [7:0] ErrNone     = 8'h00;
  localparam logic [7:0] ErrIntr     = 8'h80;
  localparam logic [7:0] ErrStillBad = 8'h81;
  localparam logic [7:0] ErrBadCmd   = 8'h82;
  localparam logic [7:0] ErrNoKey    = 8'h84;

  localparam int unsigned NumKeys    = 6;
  localparam int unsigned NumOskWords = 8;
  localparam int unsigned KeyLen     = 4;

  // Key entries
  localparam logic [2:0] EntNatj = 3'd0;
  localparam logic [2:0] EntMssp = 3'd1;
  localparam logic [2:0] EntMssd = 3'd2;
  localparam logic [2:0] EntRev  = 3'd3;
  localparam logic [2:0] EntOsk0 = 3'd4;
  localparam logic [2:0] EntOsk1 = 3'd5;

  localparam logic [31:0] KeyNames [NumKeys] = '{
    32'h4E41544A,  // NATJ
    32'h4D535350,  // MSSP
    32'h4D535344,  // MSSD
    32'h52455620,  // "REV "
    32'h4F534B30,  // OSK0
    32'h4F534B31   // OSK1
  };

  localparam logic [5:0] LenOne  = 6'd1;
  localparam logic [5:0] LenRev  = 6'd6;
  localparam logic [5:0] LenOsk  = 6'd32;

  function automatic logic [5:0] entry_len(input logic [2:0] ent);
    logic [5:0] len;
    case (ent)
      EntRev:           len = LenRev;
      EntOsk0, EntOsk1: len = LenOsk;
      default:          len = LenOne;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] rev_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h01;
      3'd1:    b = 8'h13;
      3'd2:    b = 8'h0F;
      3'd5:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/smc_key_read_port_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smc_key_read_port_controller
// Byte-wide command, data and error ports of a key-read controller.
// ----------------------------------------------------------------------------
// Each host access is one item and produces one result byte (zero for
// writes). An item is taken into an input register, evaluated against the
// controller state combinationally and its result is held in an output
// register, so one item is accepted per cycle unless the output stalls.
// The result waits in the output register for as long as the output
// stalls. The OSK bytes come from eight 64-bit configuration registers
// that are sampled when the data read is evaluated.
module smc_key_read_port_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [1:0]  port_select_i,
  input  wire logic [7:0]  write_data_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  // OSK words
  logic [63:0] osk_q [smckrp_pkg::NumOskWords];

  // input register
  logic       in_valid_q;
  logic       mode_q;
  logic [1:0] port_q;
  logic [7:0] wdata_q;

  // output register
  logic       out_valid_q;
  logic [7:0] rdata_q;
  logic [7:0] rdata_d;

  // controller state
  logic [7:0]  status_q, status_d;
  logic [7:0]  err_q, err_d;
  logic        active_q, active_d;
  logic [2:0]  kcnt_q, kcnt_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  sel_q, sel_d;
  logic [5:0]  vlen_q, vlen_d;
  logic [5:0]  vpos_q, vpos_d;

  logic out_free;
  logic advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(smckrp_pkg::NumOskWords); i++) begin
        osk_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      osk_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q  <= mode_i;
      port_q  <= port_select_i;
      wdata_q <= write_data_i;
    end
  end

  // value byte lookup
  logic [5:0] osk_pos;
  logic [7:0] osk_byte;
  logic [7:0] value_byte;
  logic [63:0] osk_word;

  always_comb begin
    osk_pos  = {(sel_q == smckrp_pkg::EntOsk1), vpos_q[4:0]};
    osk_word = osk_q[osk_pos[5:3]];
    osk_byte = osk_word[{osk_pos[2:0], 3'b000} +: 8];
    case (sel_q)
      smckrp_pkg::EntRev:                     value_byte = smckrp_pkg::rev_byte(vpos_q[2:0]);
      smckrp_pkg::EntOsk0, smckrp_pkg::EntOsk1: value_byte = osk_byte;
      default:                                value_byte = 8'h00;
    endcase
  end

  // key match
  logic       key_hit;
  logic [2:0] key_ent;

  always_comb begin
    key_hit = 1'b0;
    key_ent = '0;
    for (int e = int'(smckrp_pkg::NumKeys) - 1; e >= 0; e--) begin
      if (key_q == smckrp_pkg::KeyNames[e]) begin
        key_hit = 1'b1;
        key_ent = 3'(e);
      end
    end
  end

  // evaluate one item
  logic [5:0] vpos_inc;

  always_comb begin
    status_d = status_q;
    err_d    = err_q;
    active_d = active_q;
    kcnt_d   = kcnt_q;
    key_d    = key_q;
    sel_d    = sel_q;
    vlen_d   = vlen_q;
    vpos_d   = vpos_q;
    rdata_d  = 8'h00;
    vpos_inc = vpos_q + 6'd1;

    if (mode_q) begin
      case (port_q)
        smckrp_pkg::PortCmd: begin
          if (wdata_q == smckrp_pkg::CmdRead) begin
            if (status_q == smckrp_pkg::StIdle || status_q == smckrp_pkg::StNewCmd) begin
              active_d = 1'b1;
              status_d = smckrp_pkg::StNewCmd | smckrp_pkg::StAck;
            end else begin
              status_d = smckrp_pkg::StNewCmd;
              err_d    = smckrp_pkg::ErrIntr;
            end
          end else begin
            status_d = smckrp_pkg::StNewCmd;
            err_d    = smckrp_pkg::ErrBadCmd;
          end
          kcnt_d = '0;
          vpos_d = '0;
        end
        smckrp_pkg::PortData: begin
          if (!active_q) begin
            err_d = smckrp_pkg::ErrStillBad;
          end else if (kcnt_q < 3'(smckrp_pkg::KeyLen)) begin
            // shift in the next key character
            key_d    = {key_q[23:0], wdata_q};
            kcnt_d   = kcnt_q + 3'd1;
            status_d = smckrp_pkg::StAck;
          end else if (key_hit) begin
            sel_d    = key_ent;
            vlen_d   = smckrp_pkg::entry_len(key_ent);
            vpos_d   = '0;
            status_d = smckrp_pkg::StAck | smckrp_pkg::StReady;
            err_d    = smckrp_pkg::ErrNone;
          end else begin
            status_d = smckrp_pkg::StIdle;
            err_d    = smckrp_pkg::ErrNoKey;
          end
        end
        default: ;
      endcase
    end else begin
      case (port_q)
        smckrp_pkg::PortCmd: rdata_d = status_q;
        smckrp_pkg::PortErr: rdata_d = err_q;
        smckrp_pkg::PortData: begin
          if (!active_q) begin
            err_d = smckrp_pkg::ErrStillBad;
          end else if ((status_q & smckrp_pkg::StReady) != 8'h00 && vpos_q < vlen_q) begin
            rdata_d = value_byte;
            vpos_d  = vpos_inc;
            // drop ready after the last byte
            if (vpos_inc == vlen_q) begin
              status_d = smckrp_pkg::StIdle;
            end else begin
              status_d = smckrp_pkg::StAck | smckrp_pkg::StReady;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      err_q    <= '0;
      active_q <= 1'b0;
      kcnt_q   <= '0;
      key_q    <= '0;
      sel_q    <= '0;
      vlen_q   <= '0;
      vpos_q   <= '0;
    end else if (advance) begin
      status_q <= status_d;
      err_q    <= err_d;
      active_q <= active_d;
      kcnt_q   <= kcnt_d;
      key_q    <= key_d;
      sel_q    <= sel_d;
      vlen_q   <= vlen_d;
      vpos_q   <= vpos_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= rdata_d;
    end
  end

  // checks
  a_kcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kcnt_q <= 3'(smckrp_pkg::KeyLen))
    else $error("key byte count out of range");

  a_vpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vpos_q <= vlen_q)
    else $error("value position past value length");

  a_ready_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q & smckrp_pkg::StReady) != 8'h00 |-> active_q)
    else $error("data ready without a read command");

  a_no_advance_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(status_q) && $stable(vpos_q) && $stable(err_q))
    else $error("state changed without an item");

  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated item lost");

endmodule
`default_nettype wire
